### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, masked while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

### rtl/pscrle_pkg.sv
// Shared types, constants and helper functions of the scanline RLE decoder.
package pscrle_pkg;

  localparam int MAX_PACKETS = 4;
  localparam int OUT_DATA_W  = 80;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_STRIDE = 3'd2;
  localparam logic [2:0] REG_PCOUNT = 3'd3;
  localparam logic [2:0] REG_PLIST  = 3'd4;
  localparam logic [2:0] REG_SWAP   = 3'd5;

  localparam logic [1:0] PK_RAW   = 2'd0;
  localparam logic [1:0] PK_PURE  = 2'd1;
  localparam logic [1:0] PK_MIXED = 2'd2;
  localparam logic [1:0] PK_NONE  = 2'd3;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_PAST_WIDTH = 2'd1;
  localparam logic [1:0] ERR_ZERO_LEN   = 2'd2;
  localparam logic [1:0] ERR_ROWS       = 2'd3;

  localparam logic [7:0] MIX_BIG      = 8'd128;
  localparam logic [7:0] MIX_RUN_BIAS = 8'd127;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  stride;
    logic [2:0]  pcount;
    logic [23:0] plist;
    logic        swap;
  } cfg_t;

  typedef struct packed {
    logic [15:0] row;
    logic [15:0] pixel_x;
    logic [1:0]  channel;
    logic [17:0] byte_offset;
    logic [7:0]  sample_value;
    logic [15:0] run_length;
    logic        line_end;
    logic [1:0]  error_code;
  } res_t;

  typedef struct packed {
    logic       found;
    logic [1:0] idx;
  } nr_t;

  function automatic logic [3:0] pk_mask(logic [23:0] plist, logic [1:0] idx);
    return plist[6*idx +: 4];
  endfunction

  function automatic logic [1:0] pk_type(logic [23:0] plist, logic [1:0] idx);
    return plist[6*idx+4 +: 2];
  endfunction

  // First packet at or after 'from' that takes bytes.
  function automatic nr_t next_real(logic [2:0] from, logic [2:0] pcount,
                                    logic [23:0] plist, logic wnz);
    nr_t        r;
    logic [2:0] limit;
    r     = '0;
    limit = (pcount > 3'(MAX_PACKETS)) ? 3'(MAX_PACKETS) : pcount;
    for (int i = MAX_PACKETS - 1; i >= 0; i--) begin
      if (3'(i) >= from && 3'(i) < limit && wnz &&
          pk_mask(plist, 2'(i)) != 4'd0 && pk_type(plist, 2'(i)) != PK_NONE) begin
        r.found = 1'b1;
        r.idx   = 2'(i);
      end
    end
    return r;
  endfunction

  // k-th set channel of mask, red first; zero when k is past the last one.
  function automatic logic [1:0] channel_of(logic [3:0] mask, logic [1:0] k);
    logic [1:0] found;
    logic [2:0] n;
    found = 2'd0;
    n     = 3'd0;
    for (int c = 0; c < 4; c++) begin
      if (mask[c]) begin
        if (n == {1'b0, k}) found = 2'(c);
        n = n + 3'd1;
      end
    end
    return found;
  endfunction

endpackage

### rtl/pscrle_cfg_regs.sv
// Configuration register file of the scanline RLE decoder.
module pscrle_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [23:0]         cfg_wdata,
  output pscrle_pkg::cfg_t    cfg
);
  import pscrle_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= 16'd1;
      cfg_r.height <= 16'd1;
      cfg_r.stride <= 3'd4;
      cfg_r.pcount <= 3'd1;
      cfg_r.plist  <= 24'd0;
      cfg_r.swap   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WIDTH:  cfg_r.width  <= cfg_wdata[15:0];
        REG_HEIGHT: cfg_r.height <= cfg_wdata[15:0];
        REG_STRIDE: cfg_r.stride <= cfg_wdata[2:0];
        REG_PCOUNT: cfg_r.pcount <= cfg_wdata[2:0];
        REG_PLIST:  cfg_r.plist  <= cfg_wdata;
        REG_SWAP:   cfg_r.swap   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/pscrle_step.sv
// Decoder state and the per-byte next-state and result logic.
module pscrle_step (
  input  logic                clk,
  input  logic                rst_n,
  input  pscrle_pkg::cfg_t    cfg,
  input  logic                go,
  input  logic [7:0]          sbyte,
  output logic                res_valid,
  output pscrle_pkg::res_t    res
);
  import pscrle_pkg::*;

  localparam logic [1:0] PH_COUNT = 2'd0;
  localparam logic [1:0] PH_BIG_A = 2'd1;
  localparam logic [1:0] PH_BIG_B = 2'd2;
  localparam logic [1:0] PH_VALUE = 2'd3;

  logic [15:0] row_r, row_nxt;
  logic [15:0] x_r, x_nxt;
  logic [1:0]  pidx_r, pidx_nxt;
  logic [1:0]  chs_r, chs_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] seg_r, seg_nxt;
  logic        run_r, run_nxt;
  logic [7:0]  chigh_r, chigh_nxt;
  logic [1:0]  err_r, err_nxt;

  logic        wnz;
  logic [15:0] room;
  nr_t         nr0, nr1;
  logic [16:0] mlen;
  logic        mrun, do_start, do_value, end_line, err_fire;
  logic [1:0]  err_code;
  logic [1:0]  eff_pidx, eff_chs;
  logic [15:0] eff_seg;
  logic        eff_run;
  logic [15:0] pure_len;
  logic [3:0]  mask;
  logic [2:0]  nch;
  logic [1:0]  ch;
  logic [18:0] prod;
  logic [16:0] x_sum;
  logic [15:0] seg_new;

  assign wnz  = (cfg.width != 16'd0);
  assign room = (x_r >= cfg.width) ? 16'd0 : cfg.width - x_r;
  assign nr0  = next_real({1'b0, pidx_r}, cfg.pcount, cfg.plist, wnz);
  assign pure_len = ({8'd0, sbyte} > room) ? room : {8'd0, sbyte};

  always_comb begin
    row_nxt   = row_r;
    x_nxt     = x_r;
    pidx_nxt  = pidx_r;
    chs_nxt   = chs_r;
    phase_nxt = phase_r;
    seg_nxt   = seg_r;
    run_nxt   = run_r;
    chigh_nxt = chigh_r;
    err_nxt   = err_r;
    res       = '0;
    res_valid = 1'b0;
    mlen      = '0;
    mrun      = 1'b0;
    do_start  = 1'b0;
    do_value  = 1'b0;
    end_line  = 1'b0;
    err_fire  = 1'b0;
    err_code  = ERR_NONE;
    eff_pidx  = pidx_r;
    eff_chs   = chs_r;
    eff_seg   = seg_r;
    eff_run   = run_r;
    mask      = '0;
    nch       = '0;
    ch        = '0;
    prod      = '0;
    x_sum     = '0;
    seg_new   = '0;
    nr1       = '0;

    if (err_r != ERR_NONE) begin
      err_fire = 1'b1;
      err_code = err_r;
    end else begin
      unique case (phase_r)
        PH_COUNT: begin
          if (row_r >= cfg.height) begin
            err_fire = 1'b1;
            err_code = ERR_ROWS;
          end else if (!nr0.found) begin
            end_line = 1'b1;
          end else begin
            pidx_nxt = nr0.idx;
            case (pk_type(cfg.plist, nr0.idx))
              PK_RAW: begin
                seg_nxt   = room;
                run_nxt   = 1'b0;
                chs_nxt   = 2'd0;
                phase_nxt = PH_VALUE;
                eff_pidx  = nr0.idx;
                eff_seg   = room;
                eff_run   = 1'b0;
                eff_chs   = 2'd0;
                do_value  = 1'b1;
              end
              PK_PURE: begin
                if (pure_len != 16'd0) begin
                  seg_nxt   = pure_len;
                  run_nxt   = 1'b1;
                  chs_nxt   = 2'd0;
                  phase_nxt = PH_VALUE;
                end
              end
              PK_MIXED: begin
                if (sbyte < MIX_BIG) begin
                  mlen     = {9'd0, sbyte} + 17'd1;
                  mrun     = 1'b0;
                  do_start = 1'b1;
                end else if (sbyte == MIX_BIG) begin
                  phase_nxt = PH_BIG_A;
                end else begin
                  mlen     = {9'd0, sbyte} - {9'd0, MIX_RUN_BIAS};
                  mrun     = 1'b1;
                  do_start = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        PH_BIG_A: begin
          chigh_nxt = sbyte;
          phase_nxt = PH_BIG_B;
        end
        PH_BIG_B: begin
          mlen     = cfg.swap ? {1'b0, sbyte, chigh_r} : {1'b0, chigh_r, sbyte};
          mrun     = 1'b1;
          do_start = 1'b1;
        end
        PH_VALUE: do_value = 1'b1;
        default: ;
      endcase
    end

    if (do_start) begin
      if (mlen > {1'b0, room}) begin
        err_fire = 1'b1;
        err_code = ERR_PAST_WIDTH;
      end else if (mlen == 17'd0) begin
        err_fire = 1'b1;
        err_code = ERR_ZERO_LEN;
      end else begin
        seg_nxt   = mlen[15:0];
        run_nxt   = mrun;
        chs_nxt   = 2'd0;
        phase_nxt = PH_VALUE;
      end
    end

    if (do_value) begin
      mask = pk_mask(cfg.plist, eff_pidx);
      nch  = 3'($countones(mask));
      ch   = channel_of(mask, eff_chs);
      prod = {3'd0, x_r} * {16'd0, cfg.stride};
      res_valid        = 1'b1;
      res.row          = row_r;
      res.pixel_x      = x_r;
      res.channel      = ch;
      res.byte_offset  = prod[17:0] + {16'd0, ch};
      res.sample_value = sbyte;
      res.run_length   = eff_run ? eff_seg : 16'd1;
      if ({1'b0, eff_chs} + 3'd1 >= nch) begin
        chs_nxt = 2'd0;
        x_sum   = {1'b0, x_r} + (eff_run ? {1'b0, eff_seg} : 17'd1);
        if (eff_run) seg_new = 16'd0;
        else seg_new = (eff_seg != 16'd0) ? eff_seg - 16'd1 : 16'd0;
        x_nxt   = x_sum[15:0];
        seg_nxt = seg_new;
        if (seg_new == 16'd0) begin
          phase_nxt = PH_COUNT;
          if (x_sum[15:0] >= cfg.width) begin
            nr1 = next_real({1'b0, eff_pidx} + 3'd1, cfg.pcount, cfg.plist, wnz);
            if (!nr1.found) begin
              res.line_end = 1'b1;
              end_line     = 1'b1;
            end else begin
              pidx_nxt = nr1.idx;
              x_nxt    = 16'd0;
            end
          end
        end
      end else begin
        chs_nxt = eff_chs + 2'd1;
      end
    end

    if (end_line) begin
      row_nxt   = row_r + 16'd1;
      pidx_nxt  = 2'd0;
      x_nxt     = 16'd0;
      phase_nxt = PH_COUNT;
      chs_nxt   = 2'd0;
      seg_nxt   = 16'd0;
      run_nxt   = 1'b0;
    end

    if (err_fire) begin
      err_nxt        = err_code;
      res            = '0;
      res.row        = row_r;
      res.error_code = err_code;
      res_valid      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      x_r     <= '0;
      pidx_r  <= '0;
      chs_r   <= '0;
      phase_r <= PH_COUNT;
      seg_r   <= '0;
      run_r   <= 1'b0;
      chigh_r <= '0;
      err_r   <= ERR_NONE;
    end else if (go) begin
      row_r   <= row_nxt;
      x_r     <= x_nxt;
      pidx_r  <= pidx_nxt;
      chs_r   <= chs_nxt;
      phase_r <= phase_nxt;
      seg_r   <= seg_nxt;
      run_r   <= run_nxt;
      chigh_r <= chigh_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

### rtl/pscrle_out_reg.sv
// Result register and stream master side of the scanline RLE decoder.
module pscrle_out_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  pscrle_pkg::res_t                    res,
  output logic                                space,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pscrle_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                                out_tlast,
  output logic [1:0]                          out_tuser
);
  import pscrle_pkg::*;

  logic valid_r;
  res_t res_r;

  assign space = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (space) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'd0, res_r.run_length, res_r.sample_value, res_r.byte_offset,
                       res_r.channel, res_r.pixel_x, res_r.row};
  assign out_tlast  = res_r.line_end;
  assign out_tuser  = res_r.error_code;

endmodule

### rtl/pic_scanline_rle_decoder_core.sv
// Top level of the scanline RLE decoder: input register, decoder step, result register.
// Takes one compressed byte per cycle unless the output stalls, and gives at most one run
// write per byte; a byte is held in the input register, decoded by the state update in the
// decoder step, and its result is loaded into the result register. Count bytes and empty
// scanlines give no result. After a fault every byte returns the same error beat until reset.
// Registers (cfg_addr): 0 width, 1 height, 2 stride, 3 packet count, 4 packet list,
// 5 count byte order; reset values 1, 1, 4, 1, 0, 0. Write them only while the block is idle.
module pic_scanline_rle_decoder_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_addr,
  input  logic [23:0]                         cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // stream_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // row, pixel_x, channel, byte_offset, sample_value, run_length, zero pad
  output logic [pscrle_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                                out_tlast,  // line_end
  output logic [1:0]                          out_tuser   // error_code
);
  import pscrle_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       res_valid;
  logic       space;
  logic       go;
  logic       in_valid_r;
  logic [7:0] in_byte_r;

  assign go        = in_valid_r && space;
  assign in_tready = !in_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  pscrle_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pscrle_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .go        (go),
    .sbyte     (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  pscrle_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (go && res_valid),
    .res        (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/pscrle_checker.sv
// Port-level checks of the scanline RLE decoder, bound to the top level.
`include "assert_macros.svh"

module pscrle_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_addr,
  input  logic [23:0]                         cfg_wdata,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [7:0]                          in_tdata,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [pscrle_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                                out_tlast,
  input  logic [1:0]                          out_tuser
);
  import pscrle_pkg::*;

  logic       err_seen_r;
  logic [1:0] err_val_r;
  logic       unused_ok;

  assign unused_ok = cfg_we ^ (|cfg_addr) ^ (|cfg_wdata) ^ in_tvalid ^ in_tready ^ (|in_tdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
      err_val_r  <= ERR_NONE;
    end else if (out_tvalid && out_tready && out_tuser != ERR_NONE && !err_seen_r) begin
      err_seen_r <= 1'b1;
      err_val_r  <= out_tuser;
    end
  end

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "beat dropped while stalled")
  `ASSERT_IMPL(a_err_sticky, clk, rst_n, out_tvalid && err_seen_r, out_tuser == err_val_r, "error not held")
  `ASSERT_IMPL(a_err_clean, clk, rst_n, out_tvalid && out_tuser != ERR_NONE, out_tdata[OUT_DATA_W-1:16] == '0 && !out_tlast, "error beat carries data")
  `ASSERT_IMPL(a_run_nonzero, clk, rst_n, out_tvalid && out_tuser == ERR_NONE, out_tdata[75:60] != 16'd0 || unused_ok != unused_ok, "zero run length")

endmodule

bind pic_scanline_rle_decoder_core pscrle_checker u_pscrle_checker (.*);

### sim/tb_top.sv
// Self-checking testbench for the scanline RLE decoder core, driven and checked beat by beat.
module tb_top;
  import pscrle_pkg::*;

  typedef enum logic [1:0] {
    EXPECT_COUNT,
    COUNT_FIRST,
    COUNT_SECOND,
    EXPECT_VALUE
  } dec_phase_t;

  typedef struct packed {
    logic [15:0] row_count;
    logic [15:0] x_pos;
    logic [1:0]  pk_idx;
    logic [1:0]  ch_step;
    dec_phase_t  phase;
    logic [15:0] seg_left;
    logic        seg_run;
    logic [7:0]  count_hi;
    logic [1:0]  err;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       hold;
  } feed_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [2:0]            cfg_addr = '0;
  logic [23:0]           cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;    // stream_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // row, pixel_x, channel, byte_offset, sample_value,
                                           // run_length, zero pad
  logic                  out_tlast;        // line_end
  logic [1:0]            out_tuser;        // error_code

  feed_t      byte_feed[$];
  res_t       pending_writes[$];
  dec_state_t pred_st;
  dec_state_t gen_st;
  cfg_t       dut_cfg;
  int         big_len;
  int         fail_count = 0;
  int         beats_in = 0;
  int         beats_out = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  bit         calm = 1'b0;

  pic_scanline_rle_decoder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  function automatic logic [3:0] pkt_mask(input cfg_t c, input int i);
    return c.plist[6*i +: 4];
  endfunction

  function automatic logic [1:0] pkt_type(input cfg_t c, input int i);
    return c.plist[6*i+4 +: 2];
  endfunction

  // First packet at or after from that consumes bytes, -1 if none.
  function automatic int first_active(input cfg_t c, input int from);
    int lim;
    int p;
    lim = (c.pcount > 3'(MAX_PACKETS)) ? MAX_PACKETS : int'(c.pcount);
    p = -1;
    for (int i = 3; i >= 0; i--) begin
      if (i >= from && i < lim && c.width != 16'd0 && pkt_mask(c, i) != 4'd0 &&
          pkt_type(c, i) != PK_NONE) p = i;
    end
    return p;
  endfunction

  function automatic logic [1:0] nth_channel(input logic [3:0] mask, input logic [1:0] k,
                                             output int n);
    logic [1:0] found;
    found = 2'd0;
    n = 0;
    for (int q = 0; q < 4; q++) begin
      if (mask[q]) begin
        if (n == int'(k)) found = 2'(q);
        n++;
      end
    end
    return found;
  endfunction

  function automatic void close_line(inout dec_state_t s);
    s.row_count = s.row_count + 16'd1;
    s.pk_idx    = 2'd0;
    s.x_pos     = 16'd0;
    s.phase     = EXPECT_COUNT;
    s.ch_step   = 2'd0;
    s.seg_left  = 16'd0;
    s.seg_run   = 1'b0;
  endfunction

  function automatic bit raise_fault(inout dec_state_t s, input logic [1:0] code,
                                     output res_t r);
    s.err = code;
    r = '0;
    r.row = s.row_count;
    r.error_code = code;
    return 1'b1;
  endfunction

  function automatic bit open_segment(inout dec_state_t s, input int len, input bit run,
                                      input int room, output res_t r);
    r = '0;
    if (len > room) return raise_fault(s, ERR_PAST_WIDTH, r);
    if (len == 0) return raise_fault(s, ERR_ZERO_LEN, r);
    s.seg_left = 16'(len);
    s.seg_run  = run;
    s.ch_step  = 2'd0;
    s.phase    = EXPECT_VALUE;
    return 1'b0;
  endfunction

  // Advances the decoder state by one byte; returns 1 when a write beat is due.
  function automatic bit decode_byte(inout dec_state_t s, input cfg_t c, input logic [7:0] b,
                                     output res_t r);
    int room;
    int p;
    int len;
    int nch;
    logic [1:0] ch;
    r = '0;
    room = (s.x_pos >= c.width) ? 0 : int'(c.width) - int'(s.x_pos);
    if (s.err != ERR_NONE) return raise_fault(s, s.err, r);
    case (s.phase)
      EXPECT_COUNT: begin
        if (s.row_count >= c.height) return raise_fault(s, ERR_ROWS, r);
        p = first_active(c, int'(s.pk_idx));
        if (p < 0) begin
          close_line(s);
          return 1'b0;
        end
        s.pk_idx = 2'(p);
        case (pkt_type(c, p))
          PK_RAW: begin
            s.seg_left = 16'(room);
            s.seg_run  = 1'b0;
            s.ch_step  = 2'd0;
            s.phase    = EXPECT_VALUE;
          end
          PK_PURE: begin
            len = (int'(b) > room) ? room : int'(b);
            if (len != 0) begin
              s.seg_left = 16'(len);
              s.seg_run  = 1'b1;
              s.ch_step  = 2'd0;
              s.phase    = EXPECT_VALUE;
            end
            return 1'b0;
          end
          default: begin
            if (b == MIX_BIG) begin
              s.phase = COUNT_FIRST;
              return 1'b0;
            end
            if (b < MIX_BIG) return open_segment(s, int'(b) + 1, 1'b0, room, r);
            return open_segment(s, int'(b) - int'(MIX_RUN_BIAS), 1'b1, room, r);
          end
        endcase
      end
      COUNT_FIRST: begin
        s.count_hi = b;
        s.phase = COUNT_SECOND;
        return 1'b0;
      end
      COUNT_SECOND: begin
        return open_segment(s, int'(c.swap ? {b, s.count_hi} : {s.count_hi, b}), 1'b1,
                            room, r);
      end
      default: ;
    endcase

    ch = nth_channel(pkt_mask(c, s.pk_idx), s.ch_step, nch);
    r.row          = s.row_count;
    r.pixel_x      = s.x_pos;
    r.channel      = ch;
    r.byte_offset  = 18'(int'(s.x_pos) * int'(c.stride) + int'(ch));
    r.sample_value = b;
    r.run_length   = s.seg_run ? s.seg_left : 16'd1;
    if (int'(s.ch_step) + 1 >= nch) begin
      s.ch_step = 2'd0;
      if (s.seg_run) begin
        s.x_pos = s.x_pos + s.seg_left;
        s.seg_left = 16'd0;
      end else begin
        s.x_pos = s.x_pos + 16'd1;
        if (s.seg_left != 16'd0) s.seg_left = s.seg_left - 16'd1;
      end
      if (s.seg_left == 16'd0) begin
        s.phase = EXPECT_COUNT;
        if (s.x_pos >= c.width) begin
          p = first_active(c, int'(s.pk_idx) + 1);
          if (p < 0) begin
            r.line_end = 1'b1;
            close_line(s);
          end else begin
            s.pk_idx = 2'(p);
            s.x_pos = 16'd0;
          end
        end
      end
    end else begin
      s.ch_step = s.ch_step + 2'd1;
    end
    return 1'b1;
  endfunction

  // Mostly well-formed bytes for the current packet; never lets a fault through.
  function automatic logic [7:0] pick_byte(input dec_state_t s, input cfg_t c);
    dec_state_t probe;
    res_t r;
    logic [7:0] b;
    int p;
    int room;
    int cap;
    int k;
    b = 8'($urandom);
    room = (s.x_pos >= c.width) ? 0 : int'(c.width) - int'(s.x_pos);
    cap = (room < 128) ? room : 128;
    if (s.phase == COUNT_FIRST) begin
      b = c.swap ? big_len[7:0] : big_len[15:8];
    end else if (s.phase == COUNT_SECOND) begin
      b = c.swap ? big_len[15:8] : big_len[7:0];
    end else if (s.phase == EXPECT_COUNT) begin
      p = first_active(c, int'(s.pk_idx));
      if (p >= 0 && room > 0) begin
        k = $urandom_range(0, 19);
        if (pkt_type(c, p) == PK_PURE) begin
          if (k < 10) b = 8'($urandom_range(1, (room < 255) ? room : 255));
          else if (k < 13) b = 8'd0;
          else if (k < 16) b = 8'hFF;
        end else if (pkt_type(c, p) == PK_MIXED) begin
          if (room > 128 && k < 6) b = MIX_BIG;
          else if (k < 9) b = MIX_BIG;
          else if (k < 13) b = 8'($urandom_range(1, (cap < 8) ? cap : 8) - 1);
          else if (k < 18) b = 8'($urandom_range(1, cap) + 127);
        end
        probe = s;
        if (decode_byte(probe, c, b, r) && r.error_code != ERR_NONE) b = 8'd0;
        if (pkt_type(c, p) == PK_MIXED && b == MIX_BIG)
          big_len = (k < 6) ? room : int'($urandom_range(1, room));
      end
    end
    return b;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit hold);
    feed_t item;
    res_t r;
    item.data = b;
    item.hold = hold;
    void'(decode_byte(gen_st, dut_cfg, b, r));
    byte_feed.push_back(item);
  endtask

  // Bytes are taken from the most significant end first.
  task automatic queue_bytes(input logic [127:0] seq, input int cnt);
    for (int i = cnt - 1; i >= 0; i--) push_byte(seq[8*i +: 8], 1'b0);
  endtask

  task automatic queue_phase(input int n);
    int made;
    int hold_at;
    made = 0;
    hold_at = $urandom_range(0, n - 1);
    while ((made < n || gen_st.phase != EXPECT_COUNT || gen_st.x_pos != 16'd0 ||
            gen_st.pk_idx != 2'd0) && made < 4000) begin
      push_byte(pick_byte(gen_st, dut_cfg), made == hold_at);
      made++;
    end
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
  endtask

  task automatic write_regs(input cfg_t c);
    put_reg(REG_WIDTH, 24'(c.width));
    put_reg(REG_HEIGHT, 24'(c.height));
    put_reg(REG_STRIDE, 24'(c.stride));
    put_reg(REG_PCOUNT, 24'(c.pcount));
    put_reg(REG_PLIST, c.plist);
    put_reg(REG_SWAP, 24'(c.swap));
    @(posedge clk);
    cfg_we <= 1'b0;
    dut_cfg = c;
  endtask

  task automatic settle();
    while (byte_feed.size() != 0 || in_tvalid || pending_writes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin : drive
    feed_t item;
    res_t r;
    logic next_v;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        beats_in++;
        if (decode_byte(pred_st, dut_cfg, in_tdata, r)) pending_writes.push_back(r);
      end
      if (!in_tvalid || in_tready) begin
        next_v = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (!calm && $urandom_range(0, 99) < 10) begin
          gap_left = $urandom_range(0, 11);
        end else if (byte_feed.size() > 0 &&
                     !(byte_feed[0].hold && pending_writes.size() > 0)) begin
          item = byte_feed.pop_front();
          in_tdata <= item.data;
          next_v = 1'b1;
        end
        in_tvalid <= next_v;
      end
    end
  end

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        beats_out++;
        got.row          = out_tdata[15:0];
        got.pixel_x      = out_tdata[31:16];
        got.channel      = out_tdata[33:32];
        got.byte_offset  = out_tdata[51:34];
        got.sample_value = out_tdata[59:52];
        got.run_length   = out_tdata[75:60];
        got.line_end     = out_tlast;
        got.error_code   = out_tuser;
        if (pending_writes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected beat, expected none, actual row %0h x %0h value %0h err %0d",
                   $time, got.row, got.pixel_x, got.sample_value, got.error_code);
        end else begin
          want = pending_writes.pop_front();
          check_field("row", 32'(want.row), 32'(got.row));
          check_field("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
          check_field("channel", 32'(want.channel), 32'(got.channel));
          check_field("byte_offset", 32'(want.byte_offset), 32'(got.byte_offset));
          check_field("sample_value", 32'(want.sample_value), 32'(got.sample_value));
          check_field("run_length", 32'(want.run_length), 32'(got.run_length));
          check_field("line_end", 32'(want.line_end), 32'(got.line_end));
          check_field("error_code", 32'(want.error_code), 32'(got.error_code));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 10) begin
        stall_left = $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    cfg_t cfg;
    logic [3:0] mask;
    logic [1:0] kind;
    logic [1:0] fault;
    int lim;
    bit narrow;
    pred_st = '0;
    gen_st = '0;
    dut_cfg = '0;
    dut_cfg.width = 16'd1;
    dut_cfg.height = 16'd1;
    dut_cfg.stride = 3'd4;
    dut_cfg.pcount = 3'd1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // raw, pure (zero count, clipped count) and mixed (raw pixels, short run) in one line
    cfg.width  = 16'd3;
    cfg.height = 16'hFFFF;
    cfg.stride = 3'd4;
    cfg.pcount = 3'd3;
    cfg.plist  = {6'd0, PK_MIXED, 4'b1000, PK_PURE, 4'b0110, PK_RAW, 4'b0001};
    cfg.swap   = 1'b0;
    write_regs(cfg);
    queue_bytes(128'(88'h00FF12_00FF5678_009A81BC), 11);
    settle();

    // no packets in use: byte dropped as an empty line
    cfg.pcount = 3'd0;
    write_regs(cfg);
    queue_bytes(128'(8'h55), 1);
    settle();

    // zero width empties every packet
    cfg.pcount = 3'd3;
    cfg.width  = 16'd0;
    write_regs(cfg);
    queue_bytes(128'(8'hAA), 1);
    settle();

    // full width big counts, low byte first, skipped packets, stride 7 offset wrap
    cfg.width  = 16'hFFFF;
    cfg.stride = 3'd7;
    cfg.pcount = 3'd4;
    cfg.plist  = {PK_MIXED, 4'b0010, PK_MIXED, 4'b0001, PK_NONE, 4'b1111, PK_MIXED, 4'b0000};
    cfg.swap   = 1'b1;
    write_regs(cfg);
    queue_bytes(128'(80'h80FFFF11_80FEFF22_0033), 10);
    settle();

    for (int ph = 0; ph < 11; ph++) begin
      if (ph == 10) calm = 1'b1;
      cfg.stride = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom);
      cfg.pcount = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom);
      cfg.swap   = 1'($urandom);
      lim = (cfg.pcount > 3'(MAX_PACKETS)) ? MAX_PACKETS : int'(cfg.pcount);
      narrow = 1'b0;
      for (int i = 0; i < 4; i++) begin
        mask = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
        kind = ($urandom_range(0, 9) == 0) ? PK_NONE : 2'($urandom_range(0, 2));
        if (ph % 3 == 0 && kind != PK_NONE) kind = PK_MIXED;
        cfg.plist[6*i +: 6] = {kind, mask};
        if (i < lim && mask != 4'd0 && (kind == PK_RAW || kind == PK_PURE)) narrow = 1'b1;
      end
      if (narrow) begin
        cfg.width = ($urandom_range(0, 4) == 0) ? 16'd1 : 16'($urandom_range(2, 24));
      end else begin
        case ($urandom_range(0, 3))
          0: cfg.width = 16'd1;
          1: cfg.width = 16'hFFFF;
          2: cfg.width = 16'($urandom_range(1, 65535));
          default: cfg.width = 16'($urandom_range(1, 300));
        endcase
      end
      cfg.height = $urandom_range(0, 1) ? 16'hFFFF : 16'(int'(gen_st.row_count) + 5000);
      write_regs(cfg);
      queue_phase(90);
      settle();
    end

    // one terminal fault, then the held error on every later byte
    cfg.width  = 16'd8;
    cfg.height = 16'hFFFF;
    cfg.stride = 3'd1;
    cfg.pcount = 3'd1;
    cfg.plist  = {18'd0, PK_MIXED, 4'b0001};
    cfg.swap   = 1'b0;
    fault = 2'($urandom_range(1, 3));
    if (fault == ERR_ROWS) cfg.height = 16'd1;
    write_regs(cfg);
    case (fault)
      ERR_PAST_WIDTH: queue_bytes(128'(8'hFF), 1);
      ERR_ZERO_LEN:   queue_bytes(128'(24'h800000), 3);
      default:        queue_bytes(128'(8'h00), 1);
    endcase
    for (int i = 0; i < 8; i++) push_byte(8'($urandom), 1'b0);

    while (byte_feed.size() != 0 || in_tvalid || pending_writes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Decoded %0d input beats into %0d write beats over %0d scanlines",
             beats_in, beats_out, pred_st.row_count);
    $display("Raw, pure and mixed packets under varied layouts; ended in fault code %0d",
             pred_st.err);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
